// ----- hw/rtl/yls_pkg.sv -----
// ----------------------------------------------------------------------------
// yls_pkg
// Shared constants and constant functions for the YIQ luma sine filter.
// ----------------------------------------------------------------------------
package yls_pkg;

    localparam int COEF_FRAC_BITS_DEF  = 12;
    localparam int SINE_TABLE_BITS_DEF = 10;

    localparam int PIX_W       = 8;
    localparam int PERIOD_W    = 16;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd256;
    localparam logic                ENABLE_RESET = 1'b1;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_PERIOD = 2'd0,
        REG_ENABLE = 2'd1
    } cfg_reg_t;

    // round(m/1000 * 2^frac)
    function automatic int fxm(input int m, input int frac);
        longint num;
        num = (longint'(m) <<< frac) + 64'sd500;
        return int'(num / 64'sd1000);
    endfunction

    // Half-wave sine table entry: trunc(255*sin(pi*k/2^bits)), series in Q30.
    function automatic logic [7:0] sine_entry(input int k, input int bits);
        longint unsigned size;
        longint unsigned half;
        longint unsigned kk;
        longint unsigned u;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned t;
        longint unsigned s;
        longint unsigned v;
        longint unsigned one;
        longint unsigned pi_q30;
        size   = 64'd1 << bits;
        half   = size >> 1;
        kk     = longint'(k) & (size - 64'd1);
        one    = 64'd1 << 30;
        pi_q30 = 64'd3373259426;
        if (kk == 64'd0) begin
            return 8'd0;
        end
        if (kk == half) begin
            return 8'd255;
        end
        u  = (kk <= half) ? kk : size - kk;
        x  = (pi_q30 * u) >> bits;
        x2 = (x * x) >> 30;
        t  = one;
        t  = one - (((x2 * t) >> 30) / 64'd110);
        t  = one - (((x2 * t) >> 30) / 64'd72);
        t  = one - (((x2 * t) >> 30) / 64'd42);
        t  = one - (((x2 * t) >> 30) / 64'd20);
        t  = one - (((x2 * t) >> 30) / 64'd6);
        s = (x * t) >> 30;
        v = (64'd255 * s + 64'd64) >> 30;
        return (v > 64'd255) ? 8'd255 : v[7:0];
    endfunction

endpackage

// ----- hw/rtl/yls_pixel_if.sv -----
// ----------------------------------------------------------------------------
// yls_pixel_if
// Input pixel channel: valid/ready with ARGB bytes and end-of-frame flag.
// ----------------------------------------------------------------------------
interface yls_pixel_if;
    import yls_pkg::*;

    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] alpha_in;
    logic [PIX_W-1:0] red_in;
    logic [PIX_W-1:0] green_in;
    logic [PIX_W-1:0] blue_in;
    logic             frame_end_in;

    modport source (
        output valid, alpha_in, red_in, green_in, blue_in, frame_end_in,
        input  ready
    );

    modport sink (
        input  valid, alpha_in, red_in, green_in, blue_in, frame_end_in,
        output ready
    );
endinterface

// ----- hw/rtl/yls_result_if.sv -----
// ----------------------------------------------------------------------------
// yls_result_if
// Output pixel channel: valid/ready with filtered ARGB and end-of-frame flag.
// ----------------------------------------------------------------------------
interface yls_result_if;
    import yls_pkg::*;

    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] alpha_out;
    logic [PIX_W-1:0] red_out;
    logic [PIX_W-1:0] green_out;
    logic [PIX_W-1:0] blue_out;
    logic             frame_end_out;

    modport source (
        output valid, alpha_out, red_out, green_out, blue_out, frame_end_out,
        input  ready
    );

    modport sink (
        input  valid, alpha_out, red_out, green_out, blue_out, frame_end_out,
        output ready
    );
endinterface

// ----- hw/rtl/yls_cfg_if.sv -----
// ----------------------------------------------------------------------------
// yls_cfg_if
// Register write channel: valid/ready with register index and write data.
// ----------------------------------------------------------------------------
interface yls_cfg_if;
    import yls_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (
        output valid, index, data,
        input  ready
    );

    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

// ----- hw/rtl/yls_sine_rom.sv -----
// ----------------------------------------------------------------------------
// yls_sine_rom
// Half-wave sine table with registered read, 2^SINE_TABLE_BITS bytes.
// ----------------------------------------------------------------------------
module yls_sine_rom #(
    parameter int SINE_TABLE_BITS = yls_pkg::SINE_TABLE_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       en,
    input  logic [SINE_TABLE_BITS-1:0] addr,
    output logic [7:0]                 data_reg
);
    import yls_pkg::*;

    localparam int DEPTH = 1 << SINE_TABLE_BITS;

    logic [7:0] rom [DEPTH];

    for (genvar k = 0; k < DEPTH; k++) begin : g_rom
        assign rom[k] = sine_entry(k, SINE_TABLE_BITS);
    end

    always_ff @(posedge clk) begin
        if (en) begin
            data_reg <= rom[addr];
        end
    end

endmodule

// ----- hw/rtl/yiq_luma_sine_metallic_filter.sv -----
// ----------------------------------------------------------------------------
// yiq_luma_sine_metallic_filter
// RGB to YIQ, luma replaced by |sine| of scaled luma, YIQ back to RGB.
// ----------------------------------------------------------------------------
// Throughput: one pixel per clock; five register stages, each stalls only
// when the stage after it is full and stalled.
// Reset: pipeline empty, period_q8 = 256 (1.0), enable = 1.
// ----------------------------------------------------------------------------
module yiq_luma_sine_metallic_filter #(
    parameter int COEF_FRAC_BITS  = yls_pkg::COEF_FRAC_BITS_DEF,
    parameter int SINE_TABLE_BITS = yls_pkg::SINE_TABLE_BITS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    yls_pixel_if.sink    pixel,
    yls_result_if.source result,
    yls_cfg_if.sink      cfg
);
    import yls_pkg::*;

    localparam int F  = COEF_FRAC_BITS;
    localparam int CW = F + 1;
    localparam int PW = F + 9;
    localparam int SW = F + 12;
    localparam int TB = SINE_TABLE_BITS;
    localparam int MW = PIX_W + PERIOD_W;

    localparam logic [CW-1:0] K_YR = CW'(fxm(299, F));
    localparam logic [CW-1:0] K_YG = CW'(fxm(587, F));
    localparam logic [CW-1:0] K_YB = CW'(fxm(114, F));
    localparam logic [CW-1:0] K_IR = CW'(fxm(596, F));
    localparam logic [CW-1:0] K_IG = CW'(fxm(274, F));
    localparam logic [CW-1:0] K_IB = CW'(fxm(322, F));
    localparam logic [CW-1:0] K_QR = CW'(fxm(211, F));
    localparam logic [CW-1:0] K_QG = CW'(fxm(523, F));
    localparam logic [CW-1:0] K_QB = CW'(fxm(312, F));
    localparam logic [CW-1:0] K_RI = CW'(fxm(956, F));
    localparam logic [CW-1:0] K_RQ = CW'(fxm(621, F));
    localparam logic [CW-1:0] K_GI = CW'(fxm(272, F));
    localparam logic [CW-1:0] K_GQ = CW'(fxm(647, F));
    localparam logic [CW-1:0] K_BI = CW'(fxm(1105, F));
    localparam logic [CW-1:0] K_BQ = CW'(fxm(1702, F));

    typedef logic [PIX_W-1:0] pix_t;
    typedef logic [PW-1:0]    prod_t;

    typedef struct packed {
        pix_t alpha;
        pix_t red;
        pix_t green;
        pix_t blue;
        logic frame_end;
    } argb_t;

    function automatic prod_t mul(input pix_t a, input logic [CW-1:0] k);
        return PW'(a) * PW'(k);
    endfunction

    function automatic logic signed [SW-1:0] ext(input prod_t p);
        return $signed(SW'(p));
    endfunction

    function automatic pix_t clamp(input logic signed [SW-1:0] acc);
        logic [SW-F-1:0] sh;
        sh = acc[SW-1:F];
        if (acc[SW-1]) begin
            return '0;
        end
        if (|sh[SW-F-1:PIX_W]) begin
            return '1;
        end
        return sh[PIX_W-1:0];
    endfunction

    // registers
    logic [PERIOD_W-1:0] period_reg;
    logic                enable_reg;

    logic  v1_reg, v2_reg, v3_reg, v4_reg, vo_reg;
    logic  adv1, adv2, adv3, adv4, advo;

    argb_t pix1_reg, pix2_reg, pix3_reg, pix4_reg, pixo_reg;
    argb_t pix_in;

    prod_t yr_reg, yg_reg, yb_reg, ir_reg, ig_reg, ib_reg, qr_reg, qg_reg, qb_reg;
    prod_t yr_next, yg_next, yb_next, ir_next, ig_next, ib_next;
    prod_t qr_next, qg_next, qb_next;

    pix_t  y2_reg, i2_reg, q2_reg;
    pix_t  y2_next, i2_next, q2_next;

    logic [TB-1:0] idx3_reg, idx3_next;
    logic [MW-1:0] phase;
    pix_t          i3_reg, q3_reg;

    logic [7:0] sine4_reg;
    prod_t      ri_reg, rq_reg, gi_reg, gq_reg, bi_reg, bq_reg;
    prod_t      ri_next, rq_next, gi_next, gq_next, bi_next, bq_next;

    logic signed [SW-1:0] y4s;
    argb_t                out_next;

    // handshake
    assign advo = !vo_reg || result.ready;
    assign adv4 = !v4_reg || advo;
    assign adv3 = !v3_reg || adv4;
    assign adv2 = !v2_reg || adv3;
    assign adv1 = !v1_reg || adv2;

    assign pixel.ready = adv1;
    assign cfg.ready   = 1'b1;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            period_reg <= PERIOD_RESET;
            enable_reg <= ENABLE_RESET;
        end
        else if (cfg.valid) begin
            case (cfg.index)
                REG_PERIOD: period_reg <= cfg.data[PERIOD_W-1:0];
                REG_ENABLE: enable_reg <= cfg.data[0];
                default:    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else begin
            if (adv1) v1_reg <= pixel.valid;
            if (adv2) v2_reg <= v1_reg;
            if (adv3) v3_reg <= v2_reg;
            if (adv4) v4_reg <= v3_reg;
            if (advo) vo_reg <= v4_reg;
        end
    end

    // stage 1: forward products
    always_comb begin
        pix_in.alpha     = pixel.alpha_in;
        pix_in.red       = pixel.red_in;
        pix_in.green     = pixel.green_in;
        pix_in.blue      = pixel.blue_in;
        pix_in.frame_end = pixel.frame_end_in;
        yr_next = mul(pixel.red_in,   K_YR);
        yg_next = mul(pixel.green_in, K_YG);
        yb_next = mul(pixel.blue_in,  K_YB);
        ir_next = mul(pixel.red_in,   K_IR);
        ig_next = mul(pixel.green_in, K_IG);
        ib_next = mul(pixel.blue_in,  K_IB);
        qr_next = mul(pixel.red_in,   K_QR);
        qg_next = mul(pixel.green_in, K_QG);
        qb_next = mul(pixel.blue_in,  K_QB);
    end

    always_ff @(posedge clk) begin
        if (adv1) begin
            pix1_reg <= pix_in;
            yr_reg   <= yr_next;
            yg_reg   <= yg_next;
            yb_reg   <= yb_next;
            ir_reg   <= ir_next;
            ig_reg   <= ig_next;
            ib_reg   <= ib_next;
            qr_reg   <= qr_next;
            qg_reg   <= qg_next;
            qb_reg   <= qb_next;
        end
    end

    // stage 2: Y, I, Q sums with clamp
    always_comb begin
        y2_next = clamp(ext(yr_reg) + ext(yg_reg) + ext(yb_reg));
        i2_next = clamp(ext(ir_reg) - ext(ig_reg) - ext(ib_reg));
        q2_next = clamp(ext(qr_reg) - ext(qg_reg) + ext(qb_reg));
    end

    always_ff @(posedge clk) begin
        if (adv2) begin
            pix2_reg <= pix1_reg;
            y2_reg   <= y2_next;
            i2_reg   <= i2_next;
            q2_reg   <= q2_next;
        end
    end

    // stage 3: sine phase
    always_comb begin
        phase     = MW'(y2_reg) * MW'(period_reg);
        idx3_next = phase[PERIOD_W-1 -: TB];
    end

    always_ff @(posedge clk) begin
        if (adv3) begin
            pix3_reg <= pix2_reg;
            idx3_reg <= idx3_next;
            i3_reg   <= i2_reg;
            q3_reg   <= q2_reg;
        end
    end

    // stage 4: sine lookup and inverse products
    yls_sine_rom #(
        .SINE_TABLE_BITS (TB)
    ) u_sine_rom (
        .clk      (clk),
        .en       (adv4),
        .addr     (idx3_reg),
        .data_reg (sine4_reg)
    );

    always_comb begin
        ri_next = mul(i3_reg, K_RI);
        rq_next = mul(q3_reg, K_RQ);
        gi_next = mul(i3_reg, K_GI);
        gq_next = mul(q3_reg, K_GQ);
        bi_next = mul(i3_reg, K_BI);
        bq_next = mul(q3_reg, K_BQ);
    end

    always_ff @(posedge clk) begin
        if (adv4) begin
            pix4_reg <= pix3_reg;
            ri_reg   <= ri_next;
            rq_reg   <= rq_next;
            gi_reg   <= gi_next;
            gq_reg   <= gq_next;
            bi_reg   <= bi_next;
            bq_reg   <= bq_next;
        end
    end

    // stage 5: RGB sums, clamp, bypass select
    always_comb begin
        y4s = $signed(SW'({sine4_reg, {F{1'b0}}}));
        out_next = pix4_reg;
        if (enable_reg) begin
            out_next.red   = clamp(y4s + ext(ri_reg) + ext(rq_reg));
            out_next.green = clamp(y4s - ext(gi_reg) - ext(gq_reg));
            out_next.blue  = clamp(y4s - ext(bi_reg) + ext(bq_reg));
        end
    end

    always_ff @(posedge clk) begin
        if (advo) begin
            pixo_reg <= out_next;
        end
    end

    assign result.valid         = vo_reg;
    assign result.alpha_out     = pixo_reg.alpha;
    assign result.red_out       = pixo_reg.red;
    assign result.green_out     = pixo_reg.green;
    assign result.blue_out      = pixo_reg.blue;
    assign result.frame_end_out = pixo_reg.frame_end;

endmodule

// ----- bench/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for yiq_luma_sine_metallic_filter. A directed set of
// corner pixels is followed by random pixel traffic under several period and
// enable settings and four flow-control modes. Each output transfer is checked
// against a bit-exact software copy of the luma sine remap.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import yls_pkg::*;

    localparam int FRAC      = COEF_FRAC_BITS_DEF;
    localparam int SINE_BITS = SINE_TABLE_BITS_DEF;
    localparam int LATENCY   = 5;
    localparam int SEG_ITEMS = 170;
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;

    typedef struct packed {
        logic [7:0] alpha;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       frame_end;
    } argb_t;

    function automatic int milli_to_fix(input int milli);
        return ((milli <<< FRAC) + 500) / 1000;
    endfunction

    localparam int K_YR = milli_to_fix(299);
    localparam int K_YG = milli_to_fix(587);
    localparam int K_YB = milli_to_fix(114);
    localparam int K_IR = milli_to_fix(596);
    localparam int K_IG = milli_to_fix(274);
    localparam int K_IB = milli_to_fix(322);
    localparam int K_QR = milli_to_fix(211);
    localparam int K_QG = milli_to_fix(523);
    localparam int K_QB = milli_to_fix(312);
    localparam int K_RI = milli_to_fix(956);
    localparam int K_RQ = milli_to_fix(621);
    localparam int K_GI = milli_to_fix(272);
    localparam int K_GQ = milli_to_fix(647);
    localparam int K_BI = milli_to_fix(1105);
    localparam int K_BQ = milli_to_fix(1702);

    class remap_tracker;
        argb_t       expected_pixels[$];
        logic [15:0] period;
        logic        enable;
        int unsigned mismatches;
        int unsigned checked;

        function new();
            period     = PERIOD_RESET;
            enable     = ENABLE_RESET;
            mismatches = 0;
            checked    = 0;
        endfunction

        function void set_register(input logic [CFG_INDEX_W-1:0] idx,
                                   input logic [CFG_DATA_W-1:0] value);
            if (idx == REG_PERIOD)
            begin
                period = value;
            end
            else if (idx == REG_ENABLE)
            begin
                enable = value[0];
            end
        endfunction

        static function int clamp_byte(input int acc);
            int v;
            if (acc < 0)
            begin
                return 0;
            end
            v = acc >>> FRAC;
            return (v > 255) ? 255 : v;
        endfunction

        // trunc(255*sin(pi*k/size)) via Q30 Taylor series
        static function int half_wave_sine(input int k);
            longint unsigned size;
            longint unsigned half;
            longint unsigned kk;
            longint unsigned u;
            longint unsigned x;
            longint unsigned x2;
            longint unsigned t;
            longint unsigned s;
            longint unsigned v;
            longint unsigned one;
            longint unsigned taylor_div[5];
            size = 64'd1 << SINE_BITS;
            half = size >> 1;
            kk   = longint'(k) & (size - 64'd1);
            one  = 64'd1 << 30;
            taylor_div[0] = 64'd110;
            taylor_div[1] = 64'd72;
            taylor_div[2] = 64'd42;
            taylor_div[3] = 64'd20;
            taylor_div[4] = 64'd6;
            if (kk == 0)
            begin
                return 0;
            end
            if (kk == half)
            begin
                return 255;
            end
            u  = (kk <= half) ? kk : size - kk;
            x  = (64'd3373259426 * u) >> SINE_BITS;
            x2 = (x * x) >> 30;
            t  = one;
            for (int n = 0; n < 5; n++)
            begin
                t = one - (((x2 * t) >> 30) / taylor_div[n]);
            end
            s = (x * t) >> 30;
            v = (64'd255 * s + 64'd64) >> 30;
            return (v > 255) ? 255 : int'(v);
        endfunction

        function argb_t remap_pixel(input argb_t px);
            argb_t       res;
            int          r;
            int          g;
            int          b;
            int          luma;
            int          ich;
            int          qch;
            int          wave;
            int unsigned phase;
            res = px;
            if (!enable)
            begin
                return res;
            end
            r     = int'(px.red);
            g     = int'(px.green);
            b     = int'(px.blue);
            luma  = clamp_byte(K_YR * r + K_YG * g + K_YB * b);
            ich   = clamp_byte(K_IR * r - K_IG * g - K_IB * b);
            qch   = clamp_byte(K_QR * r - K_QG * g + K_QB * b);
            phase = (luma * int'(period)) & 32'hFFFF;
            wave  = half_wave_sine(int'(phase >> (16 - SINE_BITS)));
            res.red   = 8'(clamp_byte((wave <<< FRAC) + K_RI * ich + K_RQ * qch));
            res.green = 8'(clamp_byte((wave <<< FRAC) - K_GI * ich - K_GQ * qch));
            res.blue  = 8'(clamp_byte((wave <<< FRAC) - K_BI * ich + K_BQ * qch));
            return res;
        endfunction

        function void log_input(input argb_t px);
            expected_pixels.push_back(remap_pixel(px));
        endfunction

        function void compare_field(input string name, input int exp_v, input int act_v);
            if (exp_v != act_v)
            begin
                $error("%s: expected %0d, got %0d", name, exp_v, act_v);
                mismatches++;
            end
        endfunction

        function void check_output(input argb_t got);
            argb_t exp_px;
            if (expected_pixels.size() == 0)
            begin
                $error("output transfer with no pixel pending");
                mismatches++;
                return;
            end
            exp_px = expected_pixels.pop_front();
            checked++;
            compare_field("alpha_out", int'(exp_px.alpha), int'(got.alpha));
            compare_field("red_out", int'(exp_px.red), int'(got.red));
            compare_field("green_out", int'(exp_px.green), int'(got.green));
            compare_field("blue_out", int'(exp_px.blue), int'(got.blue));
            compare_field("frame_end_out", int'(exp_px.frame_end), int'(got.frame_end));
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned pixels_sent = 0;
    int unsigned reg_writes = 0;

    remap_tracker tracker = new();

    yls_pixel_if  pixel_bus ();
    yls_result_if result_bus ();
    yls_cfg_if    cfg_bus ();

    yiq_luma_sine_metallic_filter u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .pixel  (pixel_bus),
        .result (result_bus),
        .cfg    (cfg_bus)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    initial
    begin
        #20ms;
        $display("tb: failure");
        $finish;
    end

    always @(negedge clk)
    begin
        result_bus.ready = ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && result_bus.valid && result_bus.ready)
        begin
            tracker.check_output({result_bus.alpha_out, result_bus.red_out,
                                  result_bus.green_out, result_bus.blue_out,
                                  result_bus.frame_end_out});
        end
    end

    function automatic argb_t pix(input int a, input int r, input int g, input int b,
                                  input bit fe);
        return {8'(a), 8'(r), 8'(g), 8'(b), fe};
    endfunction

    function automatic argb_t random_pixel();
        argb_t px;
        int    shape;
        px    = pix($urandom_range(255), $urandom_range(255), $urandom_range(255),
                    $urandom_range(255), ($urandom_range(15) == 0));
        shape = $urandom_range(9);
        if (shape == 0)
        begin
            px.red   = $urandom_range(1) ? 8'hFF : 8'h00;
            px.green = $urandom_range(1) ? 8'hFF : 8'h00;
            px.blue  = $urandom_range(1) ? 8'hFF : 8'h00;
        end
        else if (shape == 1)
        begin
            px.green = px.red;
            px.blue  = px.red;
        end
        return px;
    endfunction

    task automatic send_pixel(input argb_t px);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            pixel_bus.valid = 1'b0;
            @(negedge clk);
        end
        pixel_bus.valid        = 1'b1;
        pixel_bus.alpha_in     = px.alpha;
        pixel_bus.red_in       = px.red;
        pixel_bus.green_in     = px.green;
        pixel_bus.blue_in      = px.blue;
        pixel_bus.frame_end_in = px.frame_end;
        do
        begin
            @(posedge clk);
        end
        while (!pixel_bus.ready);
        tracker.log_input(px);
        pixels_sent++;
    endtask

    // hold the input off until the pipeline has emptied
    task automatic drain_pipeline();
        @(negedge clk);
        pixel_bus.valid = 1'b0;
        while (tracker.expected_pixels.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (LATENCY + 3) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_bus.valid = 1'b1;
        cfg_bus.index = idx;
        cfg_bus.data  = value;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_bus.ready);
        tracker.set_register(idx, value);
        reg_writes++;
        @(negedge clk);
        cfg_bus.valid = 1'b0;
    endtask

    initial
    begin
        logic [15:0] seg_period[8];
        bit          seg_enable[8];

        rst_n                  = 1'b0;
        pixel_bus.valid        = 1'b0;
        pixel_bus.alpha_in     = '0;
        pixel_bus.red_in       = '0;
        pixel_bus.green_in     = '0;
        pixel_bus.blue_in      = '0;
        pixel_bus.frame_end_in = 1'b0;
        result_bus.ready       = 1'b0;
        cfg_bus.valid          = 1'b0;
        cfg_bus.index          = '0;
        cfg_bus.data           = '0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        // directed corners under reset settings
        send_pixel(pix(0, 0, 0, 0, 0));
        send_pixel(pix(255, 255, 255, 255, 1));
        send_pixel(pix(8'h80, 255, 0, 0, 0));
        send_pixel(pix(8'h7F, 0, 255, 0, 0));
        send_pixel(pix(8'h01, 0, 0, 255, 0));
        send_pixel(pix(8'hFE, 255, 0, 255, 0));
        send_pixel(pix(8'hAA, 0, 255, 255, 1));
        send_pixel(pix(8'h55, 128, 128, 128, 0));
        send_pixel(pix(8'hFF, 255, 255, 0, 0));

        // zero period forces luma to zero
        drain_pipeline();
        write_register(REG_PERIOD, 16'd0);
        send_pixel(pix(8'h33, 255, 255, 255, 0));
        send_pixel(pix(8'hCC, 200, 40, 90, 1));

        drain_pipeline();
        write_register(REG_PERIOD, 16'hFFFF);
        send_pixel(pix(8'h0F, 255, 255, 255, 0));
        send_pixel(pix(8'hF0, 1, 2, 3, 0));
        send_pixel(pix(8'h5A, 255, 0, 255, 1));

        // unknown register index must leave settings untouched
        drain_pipeline();
        write_register(REG_UNUSED, 16'h1234);
        send_pixel(pix(8'h11, 77, 150, 200, 0));

        // disabled: pass-through, upper data bits ignored
        drain_pipeline();
        write_register(REG_ENABLE, 16'hFFFE);
        send_pixel(pix(0, 255, 0, 128, 1));
        send_pixel(pix(255, 0, 255, 1, 0));
        send_pixel(pix(8'hA5, 255, 255, 255, 0));

        seg_period[0] = 16'd256;
        seg_period[1] = 16'hFFFF;
        seg_period[2] = 16'd0;
        seg_period[3] = 16'd1;
        seg_period[4] = 16'($urandom_range(65535));
        seg_period[5] = 16'd384;
        seg_period[6] = 16'($urandom_range(65535));
        seg_period[7] = 16'($urandom_range(65535));
        seg_enable    = '{1, 1, 1, 1, 1, 1, 0, 1};

        for (int seg = 0; seg < 8; seg++)
        begin
            drain_pipeline();
            write_register(REG_PERIOD, seg_period[seg]);
            write_register(REG_ENABLE, (16'($urandom) & 16'hFFFE) | 16'(seg_enable[seg]));
            case (seg % 4)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 71;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 71;
                end
                default:
                begin
                    send_idle_pct  = 35;
                    recv_stall_pct = 35;
                end
            endcase
            for (int n = 0; n < SEG_ITEMS; n++)
            begin
                if (seg == 2 && n == SEG_ITEMS / 2)
                begin
                    drain_pipeline();
                end
                send_pixel(random_pixel());
            end
        end

        drain_pipeline();
        $display("tb: %0d pixels sent, %0d results checked, %0d register writes",
                 pixels_sent, tracker.checked, reg_writes);
        $display("tb: covered period extremes, pass-through and four flow-control modes");
        if (tracker.mismatches == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
